// ----- hdl/spectral_peak_picker_defines.svh -----
// assertion macros used by the spectral peak picker top level
`ifndef SPECTRAL_PEAK_PICKER_DEFINES_SVH
`define SPECTRAL_PEAK_PICKER_DEFINES_SVH

// same-cycle implication, checked on clk, muted while reset is low
`define SPP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spectral peak picker check failed");

// next-cycle implication, checked on clk, muted while reset is low
`define SPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spectral peak picker check failed");

`endif

// ----- hdl/spp_pkg.sv -----
// shared types and constants of the spectral peak picker
package spp_pkg;

	// field widths
	localparam int RE_W       = 26;
	localparam int PWR_W      = 42;
	localparam int AMP_W      = 43;
	localparam int BIN_OUT_W  = 9;
	localparam int HZ_W       = 15;
	localparam int AMP_OUT_W  = 16;
	localparam int RANK_W     = 3;
	localparam int START_W    = 9;
	localparam int RATE_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [PWR_W-1:0] pwr_t;
	typedef logic [AMP_W-1:0] amp_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_BIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;

	// register reset values
	localparam logic [START_W-1:0] START_BIN_RST   = 9'd102;
	localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = 16'd8000;

	// output saturation limits
	localparam logic [HZ_W-1:0]      HZ_MAX  = 15'd32767;
	localparam logic [AMP_OUT_W-1:0] AMP_MAX = 16'hFFFF;

	// divide by 1000 done as a shift by 3 and a divide by 125
	// the divide by 125 is a multiply by floor(2^38/125) plus one correction on each half
	localparam int             DIV_PRE_SHIFT = 3;
	localparam logic [6:0]     DIV_ODD       = 7'd125;
	localparam int             RECIP_SHIFT   = 38;
	localparam logic [31:0]    RECIP_ODD     = 32'd2199023255;

endpackage

// ----- hdl/spp_power.sv -----
// bin counter, input register and pipelined power (re^2 + im^2) / 1000
module spp_power #(
	parameter int FFT_POINTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        take,
	input  logic signed [spp_pkg::RE_W-1:0] bin_re,
	input  logic signed [spp_pkg::RE_W-1:0] bin_im,
	input  logic                        frame_end,
	output logic                        pwr_valid,
	output logic [$clog2(FFT_POINTS/2)-1:0] pwr_bin,
	output logic                        pwr_last,
	output spp_pkg::pwr_t               pwr
);
	import spp_pkg::*;

	localparam int HALF   = FFT_POINTS / 2;
	localparam int BIN_W  = $clog2(HALF);
	localparam int STAGES = 7;

	// bin index of the next word
	logic [BIN_W-1:0] cnt_q;
	logic             last_in;

	assign last_in = frame_end || (cnt_q == BIN_W'(HALF - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= last_in ? '0 : cnt_q + 1'b1;
		end
	end

	// side band carried along the stages
	logic             vld_s [1:STAGES];
	logic [BIN_W-1:0] idx_s [1:STAGES];
	logic             end_s [1:STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= STAGES; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= take;
			for (int i = 2; i <= STAGES; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s[1] <= cnt_q;
			end_s[1] <= last_in;
			for (int i = 2; i <= STAGES; i++) begin
				idx_s[i] <= idx_s[i-1];
				end_s[i] <= end_s[i-1];
			end
		end
	end

	// stage 1: input register, dc bin drops the imaginary part
	logic signed [RE_W-1:0] re_s1;
	logic signed [RE_W-1:0] im_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			re_s1 <= bin_re;
			im_s1 <= (cnt_q == '0) ? '0 : bin_im;
		end
	end

	// stage 2: squares
	logic signed [2*RE_W-1:0] re_sq;
	logic signed [2*RE_W-1:0] im_sq;
	logic [2*RE_W-2:0]        sq_re_s2;
	logic [2*RE_W-2:0]        sq_im_s2;

	assign re_sq = re_s1 * re_s1;
	assign im_sq = im_s1 * im_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_re_s2 <= re_sq[2*RE_W-2:0];
			sq_im_s2 <= im_sq[2*RE_W-2:0];
		end
	end

	// stage 3: magnitude sum, divided by 8
	logic [2*RE_W-1:0]                 mag_sum;
	logic [2*RE_W-1-DIV_PRE_SHIFT:0]   eighth_s3;

	assign mag_sum = {1'b0, sq_re_s2} + {1'b0, sq_im_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			eighth_s3 <= mag_sum[2*RE_W-1:DIV_PRE_SHIFT];
		end
	end

	// stage 4: estimate of the upper half divided by 125
	logic [24:0] hi_part;
	logic [56:0] hi_prod;
	logic [24:0] hi_s4;
	logic [23:0] lo_s4;
	logic [17:0] qh_est_s4;

	assign hi_part = eighth_s3[48:24];
	assign hi_prod = {32'd0, hi_part} * {25'd0, RECIP_ODD};

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s4     <= hi_part;
			lo_s4     <= eighth_s3[23:0];
			qh_est_s4 <= hi_prod[RECIP_SHIFT+17:RECIP_SHIFT];
		end
	end

	// stage 5: correct the upper quotient, remainder joins the lower half
	logic [24:0] hi_back;
	logic [24:0] hi_rem;
	logic [17:0] qh_s5;
	logic [30:0] mid_s5;

	assign hi_back = 25'(qh_est_s4) * 25'(DIV_ODD);
	assign hi_rem  = hi_s4 - hi_back;

	always_ff @(posedge clk) begin
		if (en) begin
			if (hi_rem[7:0] >= {1'b0, DIV_ODD}) begin
				qh_s5  <= qh_est_s4 + 1'b1;
				mid_s5 <= {7'(hi_rem[7:0] - {1'b0, DIV_ODD}), lo_s4};
			end else begin
				qh_s5  <= qh_est_s4;
				mid_s5 <= {hi_rem[6:0], lo_s4};
			end
		end
	end

	// stage 6: estimate of the lower quotient
	logic [62:0] lo_prod;
	logic [17:0] qh_s6;
	logic [30:0] mid_s6;
	logic [23:0] ql_est_s6;

	assign lo_prod = {32'd0, mid_s5} * {31'd0, RECIP_ODD};

	always_ff @(posedge clk) begin
		if (en) begin
			qh_s6     <= qh_s5;
			mid_s6    <= mid_s5;
			ql_est_s6 <= lo_prod[RECIP_SHIFT+23:RECIP_SHIFT];
		end
	end

	// stage 7: correct the lower quotient and join both halves
	logic [30:0] lo_back;
	logic [30:0] lo_rem;
	pwr_t        pwr_s7;

	assign lo_back = 31'(ql_est_s6) * 31'(DIV_ODD);
	assign lo_rem  = mid_s6 - lo_back;

	always_ff @(posedge clk) begin
		if (en) begin
			if (lo_rem[7:0] >= {1'b0, DIV_ODD}) begin
				pwr_s7 <= {qh_s6, 24'(ql_est_s6 + 1'b1)};
			end else begin
				pwr_s7 <= {qh_s6, ql_est_s6};
			end
		end
	end

	assign pwr_valid = vld_s[STAGES];
	assign pwr_bin   = idx_s[STAGES];
	assign pwr_last  = end_s[STAGES];
	assign pwr       = pwr_s7;

endmodule

// ----- hdl/spectral_peak_picker.sv -----
// top level of the spectral peak picker: smoothing, peak table and result buffer
//
//  channel  handshake                 payload
//  bin      bin_valid / bin_stall     bin_re, bin_im, frame_end
//  peak     peak_valid / peak_stall   rank, peak_bin, peak_hz, peak_amp, last_peak
//  cfg      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one bin word is taken per cycle while bin_stall is low; a bin passes through
// 7 power stages and one smoothing stage on its way to the peak table
// a frame end loads NUM_PEAKS peak words into the result buffer, which sends them one
// per cycle while peak_stall is low; bin_stall rises only when a frame end reaches the
// table while the buffer still holds words of the frame before
// reset clears the bin counter, history, peak table and buffer busy flag and index; registers take their defaults
module spectral_peak_picker #(
	parameter int FFT_POINTS = 1024,
	parameter int NUM_PEAKS  = 5
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  bin_valid,
	output logic                                  bin_stall,
	input  logic signed [spp_pkg::RE_W-1:0]       bin_re,
	input  logic signed [spp_pkg::RE_W-1:0]       bin_im,
	input  logic                                  frame_end,
	output logic                                  peak_valid,
	input  logic                                  peak_stall,
	output logic [spp_pkg::RANK_W-1:0]            rank,
	output logic [spp_pkg::BIN_OUT_W-1:0]         peak_bin,
	output logic [spp_pkg::HZ_W-1:0]              peak_hz,
	output logic [spp_pkg::AMP_OUT_W-1:0]         peak_amp,
	output logic                                  last_peak,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [spp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [spp_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import spp_pkg::*;

	`include "spectral_peak_picker_defines.svh"

	localparam int HALF     = FFT_POINTS / 2;
	localparam int BIN_W    = $clog2(HALF);
	localparam int LOG2_PTS = $clog2(FFT_POINTS);
	localparam int IDX_W    = (NUM_PEAKS > 1) ? $clog2(NUM_PEAKS) : 1;
	localparam int HZP_W    = BIN_W + RATE_W;

	// configuration registers
	logic [START_W-1:0] start_bin_q;
	logic [RATE_W-1:0]  sample_rate_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_bin_q   <= START_BIN_RST;
			sample_rate_q <= SAMPLE_RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_BIN: begin
					start_bin_q <= cfg_data[START_W-1:0];
				end
				CFG_SAMPLE_RATE: begin
					sample_rate_q <= cfg_data[RATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline enable: hold power, smoothing and table while a frame end waits for the buffer
	logic             adv;
	logic             ob_busy_q;
	logic [IDX_W-1:0] ob_idx_q;
	logic             ob_done;
	logic             v_s8;
	logic             last_s8;

	assign ob_done   = ob_busy_q && !peak_stall && (ob_idx_q == IDX_W'(NUM_PEAKS - 1));
	assign adv       = !(v_s8 && last_s8 && ob_busy_q && !ob_done);
	assign bin_stall = !adv;

	// power pipeline
	logic             pw_valid;
	logic [BIN_W-1:0] pw_bin;
	logic             pw_last;
	pwr_t             pw_val;

	spp_power #(
		.FFT_POINTS(FFT_POINTS)
	) u_power (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.take      (bin_valid && adv),
		.bin_re    (bin_re),
		.bin_im    (bin_im),
		.frame_end (frame_end),
		.pwr_valid (pw_valid),
		.pwr_bin   (pw_bin),
		.pwr_last  (pw_last),
		.pwr       (pw_val)
	);

	// smoothing: amplitude of the previous bin and of the last bin of a frame
	pwr_t             ph0_q;
	pwr_t             ph1_q;
	logic [AMP_W-1:0] side_sum;
	amp_t             amp_prev;
	amp_t             amp_end;
	logic [BIN_W-1:0] n_s8;
	amp_t             a1_s8;
	amp_t             alast_s8;

	assign side_sum = {1'b0, ph1_q} + {1'b0, pw_val};
	assign amp_prev = (pw_bin == BIN_W'(1)) ? ({1'b0, ph0_q} + {2'b0, pw_val[PWR_W-1:1]})
		: ({1'b0, side_sum[AMP_W-1:1]} + {1'b0, ph0_q});
	assign amp_end  = {2'b0, ph0_q[PWR_W-1:1]} + {1'b0, pw_val};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph0_q <= '0;
			ph1_q <= '0;
			v_s8  <= 1'b0;
		end else if (adv) begin
			v_s8 <= pw_valid;
			if (pw_valid) begin
				if (pw_last) begin
					ph0_q <= '0;
					ph1_q <= '0;
				end else begin
					ph1_q <= ph0_q;
					ph0_q <= pw_val;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s8     <= pw_bin;
			last_s8  <= pw_last;
			a1_s8    <= amp_prev;
			alast_s8 <= amp_end;
		end
	end

	// peak candidates: the bin two back, or on a frame end the bin one back
	amp_t             ah0_q;
	amp_t             ah1_q;
	logic [BIN_W-1:0] tab_bin_q [NUM_PEAKS];
	amp_t             tab_amp_q [NUM_PEAKS];
	logic [BIN_W-1:0] m_a;
	logic [BIN_W-1:0] m_b;
	logic [BIN_W+8:0] m_a_ext;
	logic [BIN_W+8:0] m_b_ext;
	logic [BIN_W+8:0] start_ext;
	logic             cand_a_ok;
	logic             cand_b_ok;
	logic             ins;
	amp_t             cand_amp;
	logic [BIN_W-1:0] cand_bin;

	assign m_a       = n_s8 - BIN_W'(2);
	assign m_b       = n_s8 - BIN_W'(1);
	assign m_a_ext   = (BIN_W + 9)'(m_a);
	assign m_b_ext   = (BIN_W + 9)'(m_b);
	assign start_ext = (BIN_W + 9)'(start_bin_q);

	assign cand_a_ok = v_s8 && (n_s8 >= BIN_W'(3)) && (m_a_ext >= start_ext)
		&& (ah0_q > tab_amp_q[NUM_PEAKS-1]) && (ah0_q >= ah1_q) && (ah0_q > a1_s8);
	assign cand_b_ok = v_s8 && last_s8 && (n_s8 >= BIN_W'(2)) && (m_b_ext >= start_ext)
		&& (a1_s8 > tab_amp_q[NUM_PEAKS-1]) && (a1_s8 >= ah0_q) && (a1_s8 > alast_s8);

	// the two tests exclude each other, so one insertion at most
	assign ins      = cand_a_ok || cand_b_ok;
	assign cand_amp = cand_b_ok ? a1_s8 : ah0_q;
	assign cand_bin = cand_b_ok ? m_b : m_a;

	// sorted insertion, equal amplitudes keep arrival order
	logic [NUM_PEAKS-1:0] ge;
	logic [BIN_W-1:0]     tab_bin_nx [NUM_PEAKS];
	amp_t                 tab_amp_nx [NUM_PEAKS];

	always_comb begin
		for (int i = 0; i < NUM_PEAKS; i++) begin
			ge[i] = tab_amp_q[i] >= cand_amp;
		end
		if (ins && !ge[0]) begin
			tab_bin_nx[0] = cand_bin;
			tab_amp_nx[0] = cand_amp;
		end else begin
			tab_bin_nx[0] = tab_bin_q[0];
			tab_amp_nx[0] = tab_amp_q[0];
		end
		for (int i = 1; i < NUM_PEAKS; i++) begin
			if (ins && !ge[i]) begin
				tab_bin_nx[i] = ge[i-1] ? cand_bin : tab_bin_q[i-1];
				tab_amp_nx[i] = ge[i-1] ? cand_amp : tab_amp_q[i-1];
			end else begin
				tab_bin_nx[i] = tab_bin_q[i];
				tab_amp_nx[i] = tab_amp_q[i];
			end
		end
	end

	// amplitude history and peak table, cleared at each frame end
	logic commit;

	assign commit = v_s8 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ah0_q <= '0;
			ah1_q <= '0;
			for (int i = 0; i < NUM_PEAKS; i++) begin
				tab_bin_q[i] <= '0;
				tab_amp_q[i] <= '0;
			end
		end else if (commit) begin
			if (last_s8) begin
				ah0_q <= '0;
				ah1_q <= '0;
				for (int i = 0; i < NUM_PEAKS; i++) begin
					tab_bin_q[i] <= '0;
					tab_amp_q[i] <= '0;
				end
			end else begin
				if (n_s8 != '0) begin
					ah1_q <= ah0_q;
					ah0_q <= a1_s8;
				end
				for (int i = 0; i < NUM_PEAKS; i++) begin
					tab_bin_q[i] <= tab_bin_nx[i];
					tab_amp_q[i] <= tab_amp_nx[i];
				end
			end
		end
	end

	// result buffer: a copy of the final table, sent one word per cycle unless stalled
	logic [BIN_W-1:0] ob_bin_q [NUM_PEAKS];
	amp_t             ob_amp_q [NUM_PEAKS];
	logic             frame_commit;

	assign frame_commit = commit && last_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_busy_q <= 1'b0;
			ob_idx_q  <= '0;
		end else if (frame_commit) begin
			ob_busy_q <= 1'b1;
			ob_idx_q  <= '0;
		end else if (ob_done) begin
			ob_busy_q <= 1'b0;
			ob_idx_q  <= '0;
		end else if (ob_busy_q && !peak_stall) begin
			ob_idx_q <= ob_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_commit) begin
			for (int i = 0; i < NUM_PEAKS; i++) begin
				ob_bin_q[i] <= tab_bin_nx[i];
				ob_amp_q[i] <= tab_amp_nx[i];
			end
		end
	end

	// result formatting: hertz, saturation and rank
	logic [BIN_W-1:0] sel_bin;
	amp_t             sel_amp;
	logic [HZP_W-1:0] hz_prod;
	logic [HZP_W-1:0] hz_wide;
	logic [BIN_W+8:0] sel_bin_ext;
	logic [IDX_W+2:0] idx_ext;

	assign sel_bin     = ob_bin_q[ob_idx_q];
	assign sel_amp     = ob_amp_q[ob_idx_q];
	assign hz_prod     = HZP_W'(sel_bin) * HZP_W'(sample_rate_q);
	assign hz_wide     = hz_prod >> LOG2_PTS;
	assign sel_bin_ext = (BIN_W + 9)'(sel_bin);
	assign idx_ext     = (IDX_W + 3)'(ob_idx_q);

	assign peak_valid = ob_busy_q;
	assign rank       = idx_ext[RANK_W-1:0];
	assign peak_bin   = sel_bin_ext[BIN_OUT_W-1:0];
	assign peak_hz    = (hz_wide > HZP_W'(HZ_MAX)) ? HZ_MAX : hz_wide[HZ_W-1:0];
	assign peak_amp   = (sel_amp > AMP_W'(AMP_MAX)) ? AMP_MAX : sel_amp[AMP_OUT_W-1:0];
	assign last_peak  = (ob_idx_q == IDX_W'(NUM_PEAKS - 1));

	// checks
	`SPP_ASSERT_NEXT(a_frame_loads_buffer, frame_commit, peak_valid && (ob_idx_q == '0))
	`SPP_ASSERT_NEXT(a_frame_clears_table, frame_commit, tab_amp_q[0] == '0 && ah0_q == '0)
	`SPP_ASSERT_NOW(a_stall_only_when_draining, bin_stall, peak_valid && v_s8 && last_s8)
	`SPP_ASSERT_NOW(a_single_candidate, v_s8, !(cand_a_ok && cand_b_ok))

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench of the spectral peak picker: directed frames, then random frames
`timescale 1ns / 1ps

module testbench;
	import spp_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int N_POINTS       = 1024;
	localparam int HALF_BINS      = N_POINTS / 2;
	localparam int PEAK_SLOTS     = 5;
	localparam int SETTLE_CYCLES  = 24;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	// register index the block does not map
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	localparam logic signed [RE_W-1:0] PART_MAX = 26'sh1FFFFFF;
	localparam logic signed [RE_W-1:0] PART_MIN = 26'sh2000000;

	// bin 1 at a rate of 65535 Hz lands on 63 Hz
	localparam logic [HZ_W-1:0] LOW_PEAK_HZ = 15'd63;

	typedef struct packed {
		logic [RANK_W-1:0]    rank;
		logic [BIN_OUT_W-1:0] bin_no;
		logic [HZ_W-1:0]      hz;
		logic [AMP_OUT_W-1:0] amp;
		logic                 tail;
	} peak_word_t;

	typedef enum logic [1:0] {ROW_BIN, ROW_REGS} row_kind_e;
	typedef enum logic [1:0] {WANT_MODEL, WANT_EMPTY, WANT_SAT_LOW} want_e;
	typedef enum logic [1:0] {LVL_FINE, LVL_MID, LVL_FULL} level_e;

	typedef struct {
		row_kind_e              kind;
		logic signed [RE_W-1:0] re;
		logic signed [RE_W-1:0] im;
		logic                   fe;
		want_e                  want;
		logic [CFG_DATA_W-1:0]  start_data;
		logic [CFG_DATA_W-1:0]  rate_data;
	} dir_row_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         bin_valid  = 1'b0;
	logic                         bin_stall;
	logic signed [RE_W-1:0]       bin_re     = '0;
	logic signed [RE_W-1:0]       bin_im     = '0;
	logic                         frame_end  = 1'b0;
	logic                         peak_valid;
	logic                         peak_stall = 1'b0;
	logic [RANK_W-1:0]            rank;
	logic [BIN_OUT_W-1:0]         peak_bin;
	logic [HZ_W-1:0]              peak_hz;
	logic [AMP_OUT_W-1:0]         peak_amp;
	logic                         last_peak;
	logic                         cfg_valid  = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index  = CFG_START_BIN;
	logic [CFG_DATA_W-1:0]        cfg_data   = '0;

	// peak words still owed by the block, oldest first
	peak_word_t pending_peaks[$];
	int unsigned errors = 0;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        holding        = 1'b0;
	int unsigned quiet_cycles   = 0;

	// tracker state: registers, history and peak table
	logic [START_W-1:0]   start_sel = START_BIN_RST;
	logic [RATE_W-1:0]    rate_q    = SAMPLE_RATE_RST;
	int unsigned          next_bin  = 0;
	pwr_t                 pwr_back [2]          = '{default: '0};
	amp_t                 amp_back [2]          = '{default: '0};
	logic [BIN_OUT_W-1:0] best_bins [PEAK_SLOTS] = '{default: '0};
	amp_t                 best_amps [PEAK_SLOTS] = '{default: '0};

	// directed frames
	dir_row_t directed_rows [23] = '{
		// one-bin frame right after reset
		'{ROW_BIN, 0, 0, 1, WANT_EMPTY, 0, 0},
		// two-bin frame at the extremes, imaginary part of dc ignored
		'{ROW_BIN, PART_MAX, PART_MIN, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, PART_MIN, PART_MAX, 1, WANT_EMPTY, 0, 0},
		// strong peak at bin 1, below the reset start bin
		'{ROW_BIN, 0, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, PART_MAX, PART_MAX, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 0, 0, 1, WANT_EMPTY, 0, 0},
		// start bin of zero with upper data bits set, top sample rate
		'{ROW_REGS, 0, 0, 0, WANT_MODEL, 16'hFE00, 16'hFFFF},
		// same peak now searched, amplitude saturates
		'{ROW_BIN, 0, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, PART_MIN, PART_MIN, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 0, 0, 1, WANT_SAT_LOW, 0, 0},
		// equal peaks keep arrival order, one slot left empty
		'{ROW_BIN, 0, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 3000, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 0, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 0, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 0, -3000, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 0, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 0, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, -3000, 4000, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 0, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 0, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 2000, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 0, 0, 0, WANT_MODEL, 0, 0},
		'{ROW_BIN, 100, 0, 1, WANT_MODEL, 0, 0}
	};

	spectral_peak_picker DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.bin_valid  (bin_valid),
		.bin_stall  (bin_stall),
		.bin_re     (bin_re),
		.bin_im     (bin_im),
		.frame_end  (frame_end),
		.peak_valid (peak_valid),
		.peak_stall (peak_stall),
		.rank       (rank),
		.peak_bin   (peak_bin),
		.peak_hz    (peak_hz),
		.peak_amp   (peak_amp),
		.last_peak  (last_peak),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// insert a candidate peak into the sorted table
	function automatic void place_peak(input int unsigned m, input amp_t left, input amp_t mid,
		input amp_t right);
		int pos;
		if (m < 1 || m < start_sel)
			return;
		if (mid <= best_amps[PEAK_SLOTS-1])
			return;
		if (!(mid >= left && mid > right))
			return;
		pos = PEAK_SLOTS - 1;
		while (pos > 0 && best_amps[pos-1] < mid)
			pos--;
		for (int j = PEAK_SLOTS - 1; j > pos; j--) begin
			best_amps[j] = best_amps[j-1];
			best_bins[j] = best_bins[j-1];
		end
		best_amps[pos] = mid;
		best_bins[pos] = BIN_OUT_W'(m);
	endfunction

	// power, smoothing and peak search for one bin; the table comes out on a frame end
	function automatic void track_bin(input logic signed [RE_W-1:0] re,
		input logic signed [RE_W-1:0] im, input logic fe, output peak_word_t words[$]);
		longint sre;
		longint sim;
		logic [63:0] cur;
		logic [63:0] p1;
		logic [63:0] p2;
		logic [63:0] a1;
		logic [63:0] a_end;
		logic [63:0] hz_full;
		int unsigned n;
		logic closes;
		words = {};
		n = next_bin;
		sre = re;
		sim = im;
		closes = fe || (n >= HALF_BINS - 1);
		p1 = pwr_back[0];
		p2 = pwr_back[1];
		cur = 64'(sre * sre);
		if (n != 0)
			cur += 64'(sim * sim);
		cur = cur / 1000;

		// smoothed value of the bin before this one
		if (n >= 1) begin
			if (n == 1)
				a1 = p1 + cur / 2;
			else
				a1 = (p2 + cur) / 2 + p1;
			if (n >= 3)
				place_peak(n - 2, amp_back[1], amp_back[0], a1[AMP_W-1:0]);
			amp_back[1] = amp_back[0];
			amp_back[0] = a1[AMP_W-1:0];
		end

		if (!closes) begin
			pwr_back[1] = p1[PWR_W-1:0];
			pwr_back[0] = cur[PWR_W-1:0];
			next_bin = n + 1;
			return;
		end

		// edge rule for the closing bin
		if (n >= 2) begin
			a_end = p1 / 2 + cur;
			place_peak(n - 1, amp_back[1], amp_back[0], a_end[AMP_W-1:0]);
		end

		for (int k = 0; k < PEAK_SLOTS; k++) begin
			hz_full = 64'(best_bins[k]) * rate_q / N_POINTS;
			words.push_back('{
				rank:   RANK_W'(k),
				bin_no: best_bins[k],
				hz:     (hz_full > HZ_MAX) ? HZ_MAX : hz_full[HZ_W-1:0],
				amp:    (best_amps[k] > AMP_MAX) ? AMP_MAX : best_amps[k][AMP_OUT_W-1:0],
				tail:   (k == PEAK_SLOTS - 1)
			});
		end

		// new frame starts clean
		next_bin = 0;
		pwr_back = '{default: '0};
		amp_back = '{default: '0};
		best_bins = '{default: '0};
		best_amps = '{default: '0};
	endfunction

	// hand-written results of the directed frame ends
	function automatic void typed_words(input want_e want, output peak_word_t words[$]);
		words = {};
		for (int k = 0; k < PEAK_SLOTS; k++)
			words.push_back('{rank: RANK_W'(k), bin_no: '0, hz: '0, amp: '0,
				tail: (k == PEAK_SLOTS - 1)});
		if (want == WANT_SAT_LOW) begin
			words[0].bin_no = 9'd1;
			words[0].hz = LOW_PEAK_HZ;
			words[0].amp = AMP_MAX;
		end
	endfunction

	function automatic logic signed [RE_W-1:0] pick_part(input level_e level);
		int v;
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(2))
				0: return PART_MAX;
				1: return PART_MIN;
				default: return '0;
			endcase
		end
		case (level)
			LVL_FINE: v = int'($urandom_range(600)) - 300;
			LVL_MID:  v = int'($urandom_range(16000)) - 8000;
			default:  v = int'($urandom());
		endcase
		return v[RE_W-1:0];
	endfunction

	// offer one bin word, with random idle cycles in front of it
	task automatic send_bin(input logic signed [RE_W-1:0] re, input logic signed [RE_W-1:0] im,
		input logic fe, input want_e want);
		peak_word_t words[$];
		while ($urandom_range(99) < send_idle_pct) begin
			bin_valid <= 1'b0;
			@(posedge clk);
		end
		bin_valid <= 1'b1;
		bin_re <= re;
		bin_im <= im;
		frame_end <= fe;
		@(posedge clk);
		while (bin_stall)
			@(posedge clk);
		track_bin(re, im, fe, words);
		if (want != WANT_MODEL)
			typed_words(want, words);
		foreach (words[w])
			pending_peaks.push_back(words[w]);
	endtask

	task automatic send_frame(input int unsigned len, input level_e level, input logic mark_end);
		for (int unsigned b = 0; b < len; b++)
			send_bin(pick_part(level), pick_part(level), mark_end && (b == len - 1), WANT_MODEL);
	endtask

	// whole frames of random length until the bin budget is spent
	task automatic run_frames(input int unsigned budget, input int unsigned max_len);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(1, 2);
			else
				len = $urandom_range(3, max_len);
			send_frame(len, level_e'($urandom_range(2)), 1'b1);
			sent += len;
		end
	endtask

	task automatic drain_peaks();
		while (pending_peaks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_START_BIN:   start_sel = data[START_W-1:0];
			CFG_SAMPLE_RATE: rate_q = data[RATE_W-1:0];
			default: ;
		endcase
	endtask

	// registers change only once the block has gone quiet
	task automatic set_regs(input logic [CFG_DATA_W-1:0] start_data,
		input logic [CFG_DATA_W-1:0] rate_data);
		bin_valid <= 1'b0;
		drain_peaks();
		write_reg(CFG_START_BIN, start_data);
		write_reg(CFG_SAMPLE_RATE, rate_data);
		write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	// peak side: check each word taken, then pick the stall for the next cycle
	always @(posedge clk) begin
		peak_word_t got;
		peak_word_t want;
		if (arst_n && peak_valid && !peak_stall) begin
			got = '{rank: rank, bin_no: peak_bin, hz: peak_hz, amp: peak_amp, tail: last_peak};
			if (pending_peaks.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected peak word: rank %0d bin %0d hz %0d amp %0d last %0b",
						got.rank, got.bin_no, got.hz, got.amp, got.tail);
			end else begin
				want = pending_peaks.pop_front();
				if (got.rank !== want.rank || got.bin_no !== want.bin_no || got.hz !== want.hz
					|| got.amp !== want.amp || got.tail !== want.tail) begin
					errors++;
					if (errors <= REPORT_LIMIT) begin
						$write("peak word: expected rank %0d bin %0d hz %0d amp %0d last %0b, ",
							want.rank, want.bin_no, want.hz, want.amp, want.tail);
						$display("got rank %0d bin %0d hz %0d amp %0d last %0b",
							got.rank, got.bin_no, got.hz, got.amp, got.tail);
					end
				end
			end
		end
		peak_stall <= holding || ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((bin_valid && !bin_stall) || (peak_valid && !peak_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_REGS)
				set_regs(directed_rows[r].start_data, directed_rows[r].rate_data);
			else
				send_bin(directed_rows[r].re, directed_rows[r].im, directed_rows[r].fe,
					directed_rows[r].want);
		end

		// sender mostly busy, receiver stalls often
		set_regs(16'd1, 16'd8000);
		send_idle_pct = 6;
		recv_stall_pct <= 60;
		run_frames(100, 24);

		// sample rate of zero, sender idles often
		set_regs(16'd3, 16'd0);
		send_idle_pct = 60;
		recv_stall_pct <= 6;
		run_frames(100, 24);

		// no idling; receiver held off while short frames pile up
		set_regs(16'hFC02, 16'hFFFF);
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		fork
			begin
				holding <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding <= 1'b0;
			end
		join_none
		run_frames(60, 6);
		bin_valid <= 1'b0;
		while (pending_peaks.size() != 0)
			@(posedge clk);
		run_frames(60, 24);

		// start bin of 510, beyond every frame sent
		set_regs(16'd510, 16'd44100);
		run_frames(40, 24);

		bin_valid <= 1'b0;
		drain_peaks();
		if (errors == 0 && pending_peaks.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/spp_pkg.sv
hdl/spp_power.sv
hdl/spectral_peak_picker.sv
tb/testbench.sv
